>>> hw/rtl/rpn_pkg.sv
// Shared constants, codes and control types for the postfix expression evaluator.
package rpn_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned DW              = 64;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_STAR  = 8'h2A;
	localparam logic [7:0] ASCII_SLASH = 8'h2F;

	typedef logic [DW-1:0] rpn_word_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_UNDERFLOW  = 3'd1,
		ERR_DIV_ZERO   = 3'd2,
		ERR_BAD_SYMBOL = 3'd3,
		ERR_NOT_ONE    = 3'd4,
		ERR_OVERFLOW   = 3'd5
	} rpn_err_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} rpn_op_t;

	typedef enum logic [1:0] {
		CLS_DIGIT,
		CLS_OP,
		CLS_BAD
	} rpn_cls_t;

	// Controller to datapath.
	typedef struct packed {
		logic     load_in;
		logic     push;
		logic     pop_write;
		logic     md_start;
		logic     set_err;
		rpn_err_t err_code;
		logic     rd_bottom;
		logic     emit;
	} rpn_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		rpn_cls_t cls;
		rpn_op_t  op;
		logic     err_set;
		logic     full;
		logic     lt2;
		logic     rhs_zero;
		logic     last;
		logic     md_done;
		logic     out_busy;
	} rpn_stat_t;

endpackage

>>> hw/rtl/rpn_stack_evaluator.sv
// Top level of the postfix expression evaluator: controller, datapath and ports.
//
//   Channel  | Signals                          | Beat
//   symbols  | sym_valid, sym_stall, symbol, last | one ASCII symbol
//   results  | res_valid, res_stall, value, error | one result per expression
//
// One symbol is in work at a time. A digit, or a symbol that only raises or meets an
// error, steps through the decode and end states; + and - add an execute state, and *
// and / also wait on the one-bit-a-cycle shared multiply/divide unit (a zero divisor does not).
// A symbol marked last adds the emit state, held while the previous result is still stalled.
// Reset empties the stack and clears the sticky error; the stack memory itself is not
// cleared. A stalled result holds in its register while the next expression's symbols
// are accepted, until another result is due.
module rpn_stack_evaluator
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sym_valid,
	output logic        sym_stall,
	input  logic [7:0]  symbol,
	input  logic        last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] value,
	output logic [2:0]  error
);

	rpn_cmd_t  cmd;
	rpn_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rpn_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.symbol    (symbol),
		.last      (last),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.error     (error),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

>>> hw/rtl/rpn_muldiv.sv
// Shared iterative unit: shift-add multiplier and restoring divider, one bit a cycle.
module rpn_muldiv
	import rpn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      is_div,
	input  rpn_word_t a,
	input  rpn_word_t b,
	output logic      done,
	output rpn_word_t result
);

	localparam int unsigned CNTW = $clog2(DW + 1);

	rpn_word_t       acc_q;
	rpn_word_t       x_q;
	rpn_word_t       y_q;
	logic            div_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW:0]     rem_shift;
	logic [DW:0]     trial;

	assign rem_shift = {acc_q, x_q[DW-1]};
	assign trial     = rem_shift - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			acc_q <= '0;
			x_q   <= is_div ? a : b;
			y_q   <= is_div ? b : a;
		end else if (cnt_q != '0) begin
			if (div_q) begin
				// A clear borrow means the shifted remainder reaches the divisor.
				if (!trial[DW]) begin
					acc_q <= trial[DW-1:0];
					x_q   <= {x_q[DW-2:0], 1'b1};
				end else begin
					acc_q <= rem_shift[DW-1:0];
					x_q   <= {x_q[DW-2:0], 1'b0};
				end
			end else begin
				if (x_q[0]) begin
					acc_q <= acc_q + y_q;
				end
				y_q <= {y_q[DW-2:0], 1'b0};
				x_q <= {1'b0, x_q[DW-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? x_q : acc_q;

endmodule

>>> hw/rtl/rpn_dp.sv
// Datapath: input register, operand stack memory, arithmetic and result register.
module rpn_dp
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [7:0] symbol,
	input  logic      last,
	input  rpn_cmd_t  cmd,
	output rpn_stat_t stat,
	output rpn_word_t value,
	output logic [2:0] error,
	output logic      res_valid,
	input  logic      res_stall
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	rpn_word_t   mem [STACK_DEPTH];
	logic [7:0]  sym_q;
	logic        last_q;
	logic [CW-1:0] count_q;
	rpn_err_t    err_q;
	rpn_word_t   rd_a_q;
	rpn_word_t   rd_b_q;
	rpn_word_t   value_q;
	rpn_err_t    error_q;
	logic        res_valid_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] addr_a;
	logic [AW-1:0] addr_b;
	logic [AW-1:0] addr_w;
	rpn_word_t   wr_data;
	rpn_word_t   rhs;
	rpn_word_t   lhs;
	rpn_word_t   md_result;
	logic        md_done;
	rpn_cls_t    cls;
	rpn_op_t     op;
	rpn_err_t    err_final;

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign addr_a = cmd.rd_bottom ? '0 : cnt_m1[AW-1:0];
	assign addr_b = cnt_m2[AW-1:0];
	assign addr_w = cmd.push ? count_q[AW-1:0] : cnt_m2[AW-1:0];
	assign rhs    = rd_a_q;
	assign lhs    = rd_b_q;

	always_comb begin
		cls = CLS_BAD;
		op  = OP_ADD;
		if (sym_q inside {[ASCII_ZERO:ASCII_NINE]}) begin
			cls = CLS_DIGIT;
		end else if (sym_q inside {ASCII_PLUS, ASCII_MINUS, ASCII_STAR, ASCII_SLASH}) begin
			cls = CLS_OP;
		end
		case (sym_q)
			ASCII_MINUS: op = OP_SUB;
			ASCII_STAR:  op = OP_MUL;
			ASCII_SLASH: op = OP_DIV;
			default:     op = OP_ADD;
		endcase
	end

	always_comb begin
		case (op)
			OP_ADD:  wr_data = lhs + rhs;
			OP_SUB:  wr_data = lhs - rhs;
			default: wr_data = md_result;
		endcase
		if (cmd.push) begin
			wr_data = DW'(sym_q - ASCII_ZERO);
		end
	end

	always_comb begin
		if (err_q != ERR_NONE) begin
			err_final = err_q;
		end else if (count_q != CW'(1)) begin
			err_final = ERR_NOT_ONE;
		end else begin
			err_final = ERR_NONE;
		end
	end

	rpn_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.is_div (op == OP_DIV),
		.a      (lhs),
		.b      (rhs),
		.done   (md_done),
		.result (md_result)
	);

	always_ff @(posedge clk) begin
		if (cmd.push || cmd.pop_write) begin
			mem[addr_w] <= wr_data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sym_q  <= symbol;
			last_q <= last;
		end
		if (cmd.emit) begin
			error_q <= err_final;
			value_q <= (err_final == ERR_NONE) ? rd_a_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ERR_NONE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				count_q <= '0;
				err_q   <= ERR_NONE;
			end else begin
				if (cmd.push) begin
					count_q <= count_q + CW'(1);
				end else if (cmd.pop_write) begin
					count_q <= cnt_m1;
				end
				if (cmd.set_err) begin
					err_q <= cmd.err_code;
				end
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cls      = cls;
	assign stat.op       = op;
	assign stat.err_set  = (err_q != ERR_NONE);
	assign stat.full     = (count_q >= CW'(STACK_DEPTH));
	assign stat.lt2      = (count_q < CW'(2));
	assign stat.rhs_zero = (rhs == '0);
	assign stat.last     = last_q;
	assign stat.md_done  = md_done;
	assign stat.out_busy = res_valid_q && res_stall;

	assign value     = value_q;
	assign error     = error_q;
	assign res_valid = res_valid_q;

endmodule

>>> hw/rtl/rpn_ctrl.sv
// Controller FSM: steps symbols through decode and, as needed, execute and result.
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sym_valid,
	output logic      sym_stall,
	input  rpn_stat_t stat,
	output rpn_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC,
		ST_WAIT,
		ST_END,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   is_muldiv;

	assign is_muldiv = (stat.op == OP_MUL) || (stat.op == OP_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sym_valid && !stall_q) begin
						state_q <= ST_DECODE;
						stall_q <= 1'b1;
					end
				end
				ST_DECODE: begin
					if (!stat.err_set && stat.cls == CLS_OP && !stat.lt2) begin
						state_q <= ST_EXEC;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_EXEC: begin
					if (stat.op == OP_DIV && stat.rhs_zero) begin
						state_q <= ST_END;
					end else if (is_muldiv) begin
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_WAIT: begin
					if (stat.md_done) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					if (stat.last) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				ST_EMIT: begin
					if (!stat.out_busy) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.err_code = ERR_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.load_in = sym_valid && !stall_q;
			end
			ST_DECODE: begin
				if (!stat.err_set) begin
					case (stat.cls)
						CLS_DIGIT: begin
							if (stat.full) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						CLS_OP: begin
							if (stat.lt2) begin
								cmd.set_err  = 1'b1;
								cmd.err_code = ERR_UNDERFLOW;
							end
						end
						default: begin
							cmd.set_err  = 1'b1;
							cmd.err_code = ERR_BAD_SYMBOL;
						end
					endcase
				end
			end
			ST_EXEC: begin
				if (stat.op == OP_DIV && stat.rhs_zero) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ERR_DIV_ZERO;
				end else if (is_muldiv) begin
					cmd.md_start = 1'b1;
				end else begin
					cmd.pop_write = 1'b1;
				end
			end
			ST_WAIT: begin
				cmd.pop_write = stat.md_done;
			end
			ST_END: begin
				// The bottom entry is fetched here so that it is ready for the result.
				cmd.rd_bottom = stat.last;
			end
			ST_EMIT: begin
				cmd.rd_bottom = 1'b1;
				cmd.emit      = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign sym_stall = stall_q;

endmodule

>>> tb/rpn_checker.sv
`timescale 1ns / 1ps
// Checker for the postfix expression evaluator: tracks the operand stack and compares results.
module rpn_checker
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sym_valid,
	input  logic        sym_stall,
	input  logic [7:0]  symbol,
	input  logic        last,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [63:0] value,
	input  logic [2:0]  error,
	output int          mismatches,
	output int          pending,
	output int          results_checked,
	output int          error_results
);

	typedef struct packed {
		rpn_word_t val;
		rpn_err_t  err;
	} expr_result_t;

	rpn_word_t    eval_stack [STACK_DEPTH];
	int unsigned  depth_cnt;
	rpn_err_t     first_err;
	expr_result_t due_results [$];
	expr_result_t want;

	// Applies one symbol to the tracked stack. Once an expression has an error,
	// the rest of its symbols leave everything as it is.
	task eval_symbol(input logic [7:0] s);
		rpn_word_t lhs;
		rpn_word_t rhs;
		rpn_word_t res;
		begin
			if (first_err != ERR_NONE)
				return;
			if (s >= ASCII_ZERO && s <= ASCII_NINE) begin
				if (depth_cnt >= STACK_DEPTH) begin
					first_err = ERR_OVERFLOW;
				end else begin
					eval_stack[depth_cnt] = rpn_word_t'(s - ASCII_ZERO);
					depth_cnt++;
				end
				return;
			end
			if (s != ASCII_PLUS && s != ASCII_MINUS && s != ASCII_STAR && s != ASCII_SLASH) begin
				first_err = ERR_BAD_SYMBOL;
				return;
			end
			if (depth_cnt < 2) begin
				first_err = ERR_UNDERFLOW;
				return;
			end
			rhs = eval_stack[depth_cnt - 1];
			lhs = eval_stack[depth_cnt - 2];
			case (s)
				ASCII_PLUS: res = lhs + rhs;
				ASCII_MINUS: res = lhs - rhs;
				ASCII_STAR: res = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						first_err = ERR_DIV_ZERO;
						return;
					end
					res = lhs / rhs;
				end
			endcase
			eval_stack[depth_cnt - 2] = res;
			depth_cnt--;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_cnt = 0;
			first_err = ERR_NONE;
			due_results.delete();
			mismatches = 0;
			pending = 0;
			results_checked = 0;
			error_results = 0;
		end else begin
			if (res_valid && !res_stall) begin
				results_checked++;
				if (error != ERR_NONE)
					error_results++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t ns: result beat with no expression outstanding: value %h, error %0d",
							$time, value, error);
				end else begin
					want = due_results.pop_front();
					if (value !== want.val || error !== want.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t ns: value %h (expected %h), error %0d (expected %0d)",
								$time, value, want.val, error, want.err);
					end
				end
			end
			if (sym_valid && !sym_stall) begin
				eval_symbol(symbol);
				if (last) begin
					want.err = first_err;
					if (want.err == ERR_NONE && depth_cnt != 1)
						want.err = ERR_NOT_ONE;
					want.val = (want.err == ERR_NONE) ? eval_stack[0] : '0;
					due_results.push_back(want);
					depth_cnt = 0;
					first_err = ERR_NONE;
				end
			end
			pending = due_results.size();
		end
	end

endmodule

>>> tb/tb_rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// Testbench top for the postfix expression evaluator: clock, reset, symbol stimulus and verdict.
module tb_rpn_stack_evaluator
	import rpn_pkg::*;
;

	localparam int unsigned RANDOM_SYMBOLS = 850;
	localparam int unsigned DRAIN_CYCLES   = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sym_valid = 1'b0;
	logic        sym_stall;
	logic [7:0]  symbol = 8'h00;
	logic        last = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [63:0] value;
	logic [2:0]  error;
	logic        calm = 1'b0;

	int          mismatches;
	int          pending;
	int          results_checked;
	int          error_results;
	int unsigned symbols_sent = 0;
	int unsigned expressions_sent = 0;
	int unsigned random_load = 0;
	int unsigned kind;
	int unsigned pos;
	logic [7:0]  expr_q [$];

	rpn_stack_evaluator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.symbol   (symbol),
		.last     (last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value    (value),
		.error    (error)
	);

	rpn_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sym_valid      (sym_valid),
		.sym_stall      (sym_stall),
		.symbol         (symbol),
		.last           (last),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.value          (value),
		.error          (error),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_checked(results_checked),
		.error_results  (error_results)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 36);
	end

	function automatic logic [7:0] digit(input int unsigned n);
		return ASCII_ZERO + 8'(n);
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(3))
			0: return ASCII_PLUS;
			1: return ASCII_MINUS;
			2: return ASCII_STAR;
			default: return ASCII_SLASH;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task drive_symbol(input logic [7:0] s, input logic l);
		begin
			if (!calm && $urandom_range(99) < 36) begin
				sym_valid <= 1'b0;
				@(negedge clk);
				while ($urandom_range(99) < 36)
					@(negedge clk);
			end
			sym_valid <= 1'b1;
			symbol <= s;
			last <= l;
			symbols_sent++;
			do
				@(posedge clk);
			while (sym_stall);
			@(negedge clk);
		end
	endtask

	task send_expression();
		begin
			foreach (expr_q[i])
				drive_symbol(expr_q[i], i == expr_q.size() - 1);
			expressions_sent++;
		end
	endtask

	// Random postfix expression that keeps at least two values on the stack
	// before every operator, so it leaves exactly one value at the end.
	task make_wellformed(input int unsigned n_dig);
		int unsigned pushes;
		int unsigned cnt;
		begin
			expr_q.delete();
			pushes = n_dig;
			cnt = 0;
			while (pushes > 0 || cnt > 1) begin
				if (pushes > 0 && (cnt < 2 || $urandom_range(1) == 1)) begin
					expr_q.push_back(digit($urandom_range(9)));
					pushes--;
					cnt++;
				end else begin
					expr_q.push_back(pick_operator());
					cnt--;
				end
			end
		end
	endtask

	task pause_until_drained();
		begin
			sym_valid <= 1'b0;
			@(negedge clk);
			while (pending != 0)
				@(negedge clk);
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Digit extremes, each operator, wrap-around on subtraction, and the error cases.
		expr_q = '{digit(9), digit(0), ASCII_PLUS};
		send_expression();
		expr_q = '{digit(0), digit(9), ASCII_MINUS};
		send_expression();
		expr_q = '{digit(7), digit(8), ASCII_STAR, digit(3), ASCII_SLASH};
		send_expression();
		expr_q = '{digit(5), digit(0), ASCII_SLASH};
		send_expression();
		expr_q = '{ASCII_PLUS};
		send_expression();
		expr_q = '{8'h00};
		send_expression();
		// A bad symbol followed by a digit: the digit must be ignored.
		expr_q = '{8'hFF, digit(5)};
		send_expression();
		expr_q = '{digit(1), digit(2)};
		send_expression();
		expr_q.delete();
		repeat (STACK_DEPTH_DEF + 1)
			expr_q.push_back(digit($urandom_range(9)));
		send_expression();

		while (random_load < RANDOM_SYMBOLS) begin
			calm <= (expressions_sent >= 80 && expressions_sent < 130);
			if (expressions_sent % 97 == 50)
				pause_until_drained();
			kind = $urandom_range(99);
			if (kind < 85)
				make_wellformed(($urandom_range(99) < 85) ? $urandom_range(1, 6) :
					$urandom_range(7, STACK_DEPTH_DEF));
			if (kind < 70) begin
				random_load += expr_q.size();
			end else if (kind < 85) begin
				case ($urandom_range(3))
					0: expr_q.push_back(digit($urandom_range(9)));
					1: expr_q.push_front(pick_operator());
					2: begin
						pos = $urandom_range(expr_q.size() - 1);
						expr_q.insert(pos, 8'($urandom_range(255)));
					end
					default: repeat (STACK_DEPTH_DEF) expr_q.push_front(digit($urandom_range(9)));
				endcase
				random_load += expr_q.size();
			end else begin
				expr_q.delete();
				repeat ($urandom_range(1, 5))
					expr_q.push_back(8'($urandom_range(255)));
				random_load += expr_q.size();
			end
			send_expression();
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d symbols in %0d expressions, directed corner cases first.",
			symbols_sent, expressions_sent);
		$display("Checked %0d results, %0d of them carrying an error code.",
			results_checked, error_results);
		if (mismatches == 0) begin
			$display("** rpn_stack_evaluator: PASSED **");
		end else begin
			$display("%0d mismatching result beats.", mismatches);
			$display("** rpn_stack_evaluator: FAILED **");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timed out with %0d results outstanding.", pending);
		$display("** rpn_stack_evaluator: FAILED **");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_muldiv.sv
hw/rtl/rpn_dp.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_stack_evaluator.sv
tb/rpn_checker.sv
tb/tb_rpn_stack_evaluator.sv
